// ----- sv/clle_pkg.sv -----
package clle_pkg;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 5;
    localparam int KEY_W   = 31;
    localparam int AVS_W   = 8;
    localparam int LINK_W  = 6;
    localparam int ST_W    = 3;
    localparam int CLS_W   = 3;
    localparam int WORD_W  = KEY_W + AVS_W + LINK_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_INSERT = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [ST_W-1:0] ST_LOOP      = 3'd4;

    // item classes decided by the front end
    localparam logic [CLS_W-1:0] CLS_LOAD   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_HEAD   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_INSERT = 3'd2;
    localparam logic [CLS_W-1:0] CLS_WALK   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_LIST   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_BAD    = 3'd5;

    localparam logic [LINK_W-1:0] LINK_END = 6'h3F;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic              del;
        logic              slot_bad;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  anchor;
        logic [AVS_W-1:0]  avs;
        logic [LINK_W-1:0] link;
    } q_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [AVS_W-1:0]  avs;
        logic [LINK_W-1:0] link;
    } word_t;

endpackage

// ----- sv/clle_ram.sv -----
module clle_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/clle_front.sv -----
module clle_front #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [clle_pkg::OP_W-1:0]     opcode,
    input  logic [clle_pkg::SLOT_W-1:0]   slot_index,
    input  logic [clle_pkg::KEY_W-1:0]    book_key,
    input  logic [clle_pkg::KEY_W-1:0]    anchor_key,
    input  logic [clle_pkg::AVS_W-1:0]    avail_status,
    input  logic [clle_pkg::LINK_W-1:0]   next_slot,
    output logic                          q_valid,
    input  logic                          q_pop,
    output clle_pkg::q_item_t             q_item
);
    import clle_pkg::*;

    q_item_t   entry_reg [2];
    logic      wr_ptr_reg, wr_ptr_next;
    logic      rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic      push, pop;
    q_item_t   cls_item;

    always_comb
    begin
        cls_item          = '0;
        cls_item.slot     = slot_index;
        cls_item.key      = book_key;
        cls_item.anchor   = anchor_key;
        cls_item.avs      = avail_status;
        cls_item.link     = next_slot;
        cls_item.slot_bad = (32'(slot_index) >= NUM_SLOTS);
        case (opcode)
            OP_LOAD:   cls_item.cls = CLS_LOAD;
            OP_HEAD:   cls_item.cls = CLS_HEAD;
            OP_INSERT: cls_item.cls = CLS_INSERT;
            OP_DELETE:
            begin
                cls_item.cls = CLS_WALK;
                cls_item.del = 1'b1;
            end
            OP_SEARCH: cls_item.cls = CLS_WALK;
            OP_LIST:   cls_item.cls = CLS_LIST;
            default:   cls_item.cls = CLS_BAD;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

// ----- sv/clle_back.sv -----
module clle_back #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  clle_pkg::q_item_t             q_item,
    output logic                          strobe,
    output logic [clle_pkg::ST_W-1:0]     status,
    output logic [clle_pkg::KEY_W-1:0]    found_key,
    output logic [clle_pkg::AVS_W-1:0]    found_status,
    output logic [clle_pkg::SLOT_W-1:0]   found_slot,
    output logic                          last
);
    import clle_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_INS2 = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_LIST = 3'd6;

    typedef struct packed {
        logic          ok;
        logic [IW-1:0] idx;
    } dec_t;

    logic [2:0]           state_reg, state_next;
    q_item_t              item_reg, item_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        prev_reg, prev_next;
    logic                 prev_ok_reg, prev_ok_next;
    word_t                prev_word_reg, prev_word_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        anc_idx_reg, anc_idx_next;
    word_t                anc_word_reg, anc_word_next;

    logic                 strobe_reg, strobe_next;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [AVS_W-1:0]     avs_reg, avs_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 last_reg, last_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;
    word_t                rd;
    dec_t                 head_dec, link_dec;
    logic [IW:0]          ins_slot;

    function automatic dec_t decode(input logic [LINK_W-1:0] raw,
                                    input logic [NUM_SLOTS-1:0] vmask);
        dec_t d;
        d.idx = IW'(raw[SLOT_W-1:0]);
        d.ok  = !raw[LINK_W-1] && (32'(raw[SLOT_W-1:0]) < NUM_SLOTS) && vmask[d.idx];
        return d;
    endfunction

    clle_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd       = word_t'(ram_rdata);
    assign head_dec = decode(head_reg, valid_reg);
    assign link_dec = decode(rd.link, valid_reg);
    // slot right after the one on the read port during the anchor scan
    assign ins_slot = {1'b0, cur_reg} + (IW+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_ok_next   = prev_ok_reg;
        prev_word_next = prev_word_reg;
        cnt_next       = cnt_reg;
        anc_idx_next   = anc_idx_reg;
        anc_word_next  = anc_word_reg;
        strobe_next    = 1'b0;
        status_next    = ST_OK;
        key_next       = '0;
        avs_next       = '0;
        slot_next      = '0;
        last_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (item_reg.cls)
                    CLS_LOAD:
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        slot_next   = item_reg.slot;
                        if (item_reg.slot_bad)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = IW'(item_reg.slot);
                            ram_wdata  = {item_reg.key, item_reg.avs, item_reg.link};
                            valid_next[IW'(item_reg.slot)] = 1'b1;
                            key_next   = item_reg.key;
                            avs_next   = item_reg.avs;
                        end
                    end
                    CLS_HEAD:
                    begin
                        if (item_reg.slot_bad)
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                            slot_next   = item_reg.slot;
                        end
                        else
                        begin
                            head_next  = {1'b0, item_reg.slot};
                            ram_raddr  = IW'(item_reg.slot);
                            state_next = S_HEAD;
                        end
                    end
                    CLS_INSERT:
                    begin
                        ram_raddr  = '0;
                        cur_next   = '0;
                        state_next = S_SCAN;
                    end
                    CLS_WALK, CLS_LIST:
                    begin
                        if (!head_dec.ok)
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            status_next = (item_reg.cls == CLS_LIST) ? ST_EMPTY
                                                                     : ST_NOT_FOUND;
                        end
                        else
                        begin
                            ram_raddr    = head_dec.idx;
                            cur_next     = head_dec.idx;
                            cnt_next     = '0;
                            prev_ok_next = 1'b0;
                            state_next   = (item_reg.cls == CLS_LIST) ? S_LIST : S_WALK;
                        end
                    end
                    default:
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            S_HEAD:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                slot_next   = item_reg.slot;
                if (valid_reg[IW'(item_reg.slot)])
                begin
                    key_next = rd.key;
                    avs_next = rd.avs;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // cur_reg is the slot whose data is on the read port
                if (valid_reg[cur_reg] && rd.key == item_reg.anchor)
                begin
                    anc_idx_next = cur_reg;
                    strobe_next  = 1'b1;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                    if (32'(ins_slot) >= NUM_SLOTS || valid_reg[IW'(ins_slot)])
                    begin
                        status_next = ST_NO_INSERT;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = IW'(ins_slot);
                        ram_wdata     = {item_reg.key, item_reg.avs, rd.link};
                        valid_next[IW'(ins_slot)] = 1'b1;
                        anc_word_next = '{key: rd.key, avs: rd.avs,
                                          link: LINK_W'(ins_slot)};
                        key_next      = item_reg.key;
                        avs_next      = item_reg.avs;
                        slot_next     = SLOT_W'(ins_slot);
                        state_next    = S_INS2;
                    end
                end
                else if (cur_reg == IW'(NUM_SLOTS - 1))
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next  = cur_reg + IW'(1);
                    ram_raddr = cur_reg + IW'(1);
                end
            end
            S_INS2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = anc_idx_reg;
                ram_wdata  = anc_word_reg;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (rd.key == item_reg.key)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    key_next    = rd.key;
                    avs_next    = rd.avs;
                    slot_next   = SLOT_W'(cur_reg);
                    state_next  = S_IDLE;
                    if (item_reg.del)
                    begin
                        valid_next[cur_reg] = 1'b0;
                        if (!prev_ok_reg)
                        begin
                            head_next = rd.link;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = prev_reg;
                            ram_wdata = {prev_word_reg.key, prev_word_reg.avs, rd.link};
                        end
                    end
                end
                else if (cnt_reg == IW'(NUM_SLOTS - 1) || !link_dec.ok)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = link_dec.ok ? ST_LOOP : ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_raddr      = link_dec.idx;
                    cur_next       = link_dec.idx;
                    prev_next      = cur_reg;
                    prev_ok_next   = 1'b1;
                    prev_word_next = rd;
                    cnt_next       = cnt_reg + IW'(1);
                end
            end
            S_LIST:
            begin
                strobe_next = 1'b1;
                key_next    = rd.key;
                avs_next    = rd.avs;
                slot_next   = SLOT_W'(cur_reg);
                if (!link_dec.ok)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == IW'(NUM_SLOTS - 1))
                begin
                    last_next   = 1'b1;
                    status_next = ST_LOOP;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_raddr = link_dec.idx;
                    cur_next  = link_dec.idx;
                    cnt_next  = cnt_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            head_reg   <= LINK_END;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            head_reg   <= head_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_ok_reg   <= prev_ok_next;
        prev_word_reg <= prev_word_next;
        cnt_reg       <= cnt_next;
        anc_idx_reg   <= anc_idx_next;
        anc_word_reg  <= anc_word_next;
        status_reg    <= status_next;
        key_reg       <= key_next;
        avs_reg       <= avs_next;
        slot_reg      <= slot_next;
    end

    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign found_key    = key_reg;
    assign found_status = avs_reg;
    assign found_slot   = slot_reg;
    assign last         = last_reg;

endmodule

// ----- sv/cursor_linked_list_engine.sv -----
// cursor linked list engine: a table of slots (key, status byte, link, valid
// mark) chained into a list from a head pointer
// command channel: an item is taken at a clock edge where start is high and
// busy is low; busy rises only while the two-entry command queue is full
// result channel: each result sits on the result ports for one cycle with
// strobe high; last marks the final result of an item; the receiver has no
// way to stall, so results are never held back
// steps: load, bad opcode and out-of-range slots answer from the execute
// state after the item leaves the queue, set head after one more read; insert
// scans slots one per cycle from slot 0, then rewrites the anchor link after
// its result; delete and search walk the chain one slot per cycle;
// list gives one result per cycle along the chain
// the walk rate is set by the single read port of the slot memory, whose
// registered read data feeds the next read address through the link decode
// reset clears the valid marks and sets the head to end of list; no clearing
// pass runs, so the block takes items right after reset
module cursor_linked_list_engine #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [clle_pkg::OP_W-1:0]     opcode,
    input  logic [clle_pkg::SLOT_W-1:0]   slot_index,
    input  logic [clle_pkg::KEY_W-1:0]    book_key,
    input  logic [clle_pkg::KEY_W-1:0]    anchor_key,
    input  logic [clle_pkg::AVS_W-1:0]    avail_status,
    input  logic signed [clle_pkg::LINK_W-1:0] next_slot,
    output logic                          strobe,
    output logic [clle_pkg::ST_W-1:0]     status,
    output logic [clle_pkg::KEY_W-1:0]    found_key,
    output logic [clle_pkg::AVS_W-1:0]    found_status,
    output logic [clle_pkg::SLOT_W-1:0]   found_slot,
    output logic                          last
);
    import clle_pkg::*;

    // queue between the classifying front end and the executing back end
    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    clle_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .book_key     (book_key),
        .anchor_key   (anchor_key),
        .avail_status (avail_status),
        .next_slot    (next_slot),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item)
    );

    // back end owns the slot memory, valid marks and head pointer
    clle_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .strobe       (strobe),
        .status       (status),
        .found_key    (found_key),
        .found_status (found_status),
        .found_slot   (found_slot),
        .last         (last)
    );

    // an accepted item is waiting in the queue on the next cycle
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> q_valid)
        else $error("accepted item missing from queue");

    // last only marks a result that is being delivered
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // empty list and error codes always close an item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> last)
        else $error("error status on a non-final result");

    // the queue is never popped while a non-final result is on the ports
    a_pop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> !q_pop)
        else $error("queue popped during a list");

endmodule
